// ===== rtl/core/fotd_pkg.sv =====
// ----------------------------------------------------------------------------
// fotd_pkg
// Shared types, codes and sizes of the flow ordered task dispatcher.
// ----------------------------------------------------------------------------
package fotd_pkg;

	localparam int FLOW_W       = 16;
	localparam int TAG_W        = 16;
	localparam int ACTION_W     = 2;
	localparam int STATUS_W     = 2;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 40;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int WORKERS_DEF     = 8;

	localparam logic [ACTION_W-1:0] ACT_ENQ      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DONE     = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_IDLE = 2'd3;

	typedef struct packed {
		logic [FLOW_W-1:0] flow;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic enq_en;
		logic deq_en;
	} cell_ctrl_t;

	typedef struct packed {
		logic              set_en;
		logic              clr_en;
		logic [FLOW_W-1:0] set_flow;
	} busy_ctrl_t;

endpackage

// ===== rtl/core/fotd_cell.sv =====
// ----------------------------------------------------------------------------
// fotd_cell
// One queue slot: holds a request, checks its flow against the busy table and
// takes the entry of its younger neighbour when the queue closes up.
// ----------------------------------------------------------------------------
module fotd_cell #(
	parameter int WORKERS = fotd_pkg::WORKERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fotd_pkg::cell_ctrl_t        ctrl,
	input  fotd_pkg::entry_t            req_entry,
	input  logic [WORKERS-1:0]          busy_valid,
	input  logic [fotd_pkg::FLOW_W-1:0] busy_flow [WORKERS],
	input  logic                        prev_valid,
	input  logic                        next_valid,
	input  fotd_pkg::entry_t            next_entry,
	input  logic                        found_in,
	input  fotd_pkg::entry_t            grant_in,
	output logic                        valid,
	output fotd_pkg::entry_t            entry,
	output logic                        found_out,
	output fotd_pkg::entry_t            grant_out
);
	import fotd_pkg::*;

	logic               valid_q;
	entry_t             entry_q;
	logic [WORKERS-1:0] hit_vec;
	logic               ready;
	logic               pick;
	logic               shift;
	logic               load;

	always_comb begin
		for (int w = 0; w < WORKERS; w++) begin
			hit_vec[w] = busy_valid[w] && (busy_flow[w] == entry_q.flow);
		end
	end

	assign ready     = valid_q && !(|hit_vec);
	assign pick      = ready && !found_in;
	assign found_out = found_in || ready;
	assign grant_out = pick ? entry_q : grant_in;
	assign shift     = ctrl.deq_en && found_out;
	assign load      = ctrl.enq_en && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (load) begin
			entry_q <= req_entry;
		end
	end

	assign valid = valid_q;
	assign entry = entry_q;

endmodule

// ===== rtl/core/fotd_busy.sv =====
// ----------------------------------------------------------------------------
// fotd_busy
// Table of flows handed to workers: marks on dispatch, clears on completion.
// ----------------------------------------------------------------------------
module fotd_busy #(
	parameter int WORKERS = fotd_pkg::WORKERS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fotd_pkg::busy_ctrl_t        ctrl,
	input  logic [fotd_pkg::FLOW_W-1:0] req_flow,
	output logic [WORKERS-1:0]          busy_valid,
	output logic [fotd_pkg::FLOW_W-1:0] busy_flow [WORKERS],
	output logic                        free_any,
	output logic                        req_hit
);
	import fotd_pkg::*;

	logic [WORKERS-1:0] valid_q;
	logic [FLOW_W-1:0]  flow_q [WORKERS];
	logic [WORKERS-1:0] hit_vec;
	logic [WORKERS-1:0] free_oh;

	always_comb begin
		for (int w = 0; w < WORKERS; w++) begin
			hit_vec[w] = valid_q[w] && (flow_q[w] == req_flow);
		end
	end

	assign free_oh  = ~valid_q & (valid_q + {{(WORKERS-1){1'b0}}, 1'b1});
	assign free_any = !(&valid_q);
	assign req_hit  = |hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.set_en) begin
			valid_q <= valid_q | free_oh;
		end else if (ctrl.clr_en) begin
			valid_q <= valid_q & ~hit_vec;
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < WORKERS; w++) begin
			if (ctrl.set_en && free_oh[w]) begin
				flow_q[w] <= ctrl.set_flow;
			end
		end
	end

	assign busy_valid = valid_q;
	assign busy_flow  = flow_q;

endmodule

// ===== rtl/core/flow_ordered_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// flow_ordered_task_dispatcher
// Arrival ordered task queue with per-flow exclusion: dispatch hands out the
// oldest task whose flow is not held by a worker.
// ----------------------------------------------------------------------------
// A result is registered from the execute state, once the output register is free.
// A new request is taken only after the single execute step, which searches the
// cell chain and updates the busy table, has finished with the last one.
// A result waiting on the output does not block acceptance of the next request.
// Reset clears the queue valid bits, the busy table valid bits, the control
// state and the output valid at once; no clearing pass.
module flow_ordered_task_dispatcher #(
	parameter int QUEUE_DEPTH = fotd_pkg::QUEUE_DEPTH_DEF,
	parameter int WORKERS     = fotd_pkg::WORKERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [15:0] flow_id, [31:16] task_tag
	input  logic [fotd_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] action
	input  logic [fotd_pkg::ACTION_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] status, [2] wake, [18:3] granted_flow, [34:19] granted_tag, rest zero
	output logic [fotd_pkg::M_TDATA_W-1:0] m_tdata
);
	import fotd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t              state_q;
	logic [ACTION_W-1:0] action_q;
	entry_t              req_q;
	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic                go;
	logic                full;
	logic                any_ready;
	entry_t              grant;
	cell_ctrl_t          cell_ctrl;
	busy_ctrl_t          busy_ctrl;
	logic [WORKERS-1:0]  busy_valid;
	logic [FLOW_W-1:0]   busy_flow [WORKERS];
	logic                free_any;
	logic                req_hit;
	logic [STATUS_W-1:0] status;
	logic                wake;
	entry_t              grant_out;

	logic                cell_valid [QUEUE_DEPTH+1];
	entry_t              cell_entry [QUEUE_DEPTH+1];
	logic                found_chain [QUEUE_DEPTH+1];
	entry_t              grant_chain [QUEUE_DEPTH+1];

	assign s_tready = (state_q == S_IDLE);
	assign go       = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_EXEC;
				S_EXEC: if (go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_q <= s_tuser;
			req_q    <= '{flow: s_tdata[FLOW_W-1:0], tag: s_tdata[FLOW_W+TAG_W-1:FLOW_W]};
		end
	end

	assign cell_valid[QUEUE_DEPTH]  = 1'b0;
	assign cell_entry[QUEUE_DEPTH]  = '0;
	assign found_chain[0]           = 1'b0;
	assign grant_chain[0]           = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic prev_valid;
		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_valid = cell_valid[i-1];
		end
		fotd_cell #(
			.WORKERS (WORKERS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.req_entry  (req_q),
			.busy_valid (busy_valid),
			.busy_flow  (busy_flow),
			.prev_valid (prev_valid),
			.next_valid (cell_valid[i+1]),
			.next_entry (cell_entry[i+1]),
			.found_in   (found_chain[i]),
			.grant_in   (grant_chain[i]),
			.valid      (cell_valid[i]),
			.entry      (cell_entry[i]),
			.found_out  (found_chain[i+1]),
			.grant_out  (grant_chain[i+1])
		);
	end

	assign full      = cell_valid[QUEUE_DEPTH-1];
	assign any_ready = found_chain[QUEUE_DEPTH];
	assign grant     = grant_chain[QUEUE_DEPTH];

	fotd_busy #(
		.WORKERS (WORKERS)
	) u_busy (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (busy_ctrl),
		.req_flow   (req_q.flow),
		.busy_valid (busy_valid),
		.busy_flow  (busy_flow),
		.free_any   (free_any),
		.req_hit    (req_hit)
	);

	always_comb begin
		cell_ctrl = '0;
		busy_ctrl = '0;
		status    = STAT_OK;
		wake      = 1'b0;
		grant_out = '0;
		busy_ctrl.set_flow = grant.flow;
		case (action_q)
			ACT_ENQ: begin
				if (full) begin
					status = STAT_FULL;
				end else begin
					cell_ctrl.enq_en = go;
					wake             = !req_hit;
				end
			end
			ACT_DISPATCH: begin
				if (free_any && any_ready) begin
					cell_ctrl.deq_en = go;
					busy_ctrl.set_en = go;
					grant_out        = grant;
				end else begin
					status = STAT_NONE;
				end
			end
			ACT_DONE: begin
				if (req_hit) begin
					busy_ctrl.clr_en = go;
				end else begin
					status = STAT_IDLE;
				end
			end
			default: begin
				status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_data_q <= {{(M_TDATA_W-STATUS_W-1-FLOW_W-TAG_W){1'b0}},
				grant_out.tag, grant_out.flow, wake, status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
